FILE: rtl/mppt_pkg.sv
// package: shared types, codes and constants of the perturb-and-observe tracker
package mppt_pkg;

  localparam int unsigned PERIOD_COUNTS = 1024;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned VOLT_W  = 14;
  localparam int unsigned CURR_W  = 16;
  localparam int unsigned DUTY_W  = 7;
  localparam int unsigned STEP_W  = 5;
  localparam int unsigned LIMIT_W = 15;
  localparam int unsigned DEAD_W  = 8;
  localparam int unsigned CMP_W   = 10;
  localparam int unsigned POWER_W = 31;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 15;

  localparam int unsigned DUTY_LEVELS = 2 ** DUTY_W;
  localparam logic [DUTY_W-1:0] DUTY_FULL_SCALE = DUTY_W'(100);

  localparam logic [DUTY_W-1:0]  RST_DUTY_FLOOR    = DUTY_W'(5);
  localparam logic [DUTY_W-1:0]  RST_DUTY_CEILING  = DUTY_W'(70);
  localparam logic [STEP_W-1:0]  RST_STEP_SIZE     = STEP_W'(1);
  localparam logic [VOLT_W-1:0]  RST_BATTERY_LIMIT = VOLT_W'(1440);
  localparam logic [LIMIT_W-1:0] RST_CURRENT_LIMIT = LIMIT_W'(5000);
  localparam logic [DEAD_W-1:0]  RST_DEAD_TIME     = DEAD_W'(61);
  localparam logic [DUTY_W-1:0]  RST_DUTY_NOW      = DUTY_W'(40);

  typedef enum logic [OP_W-1:0] {
    OpCurrentCheck = 3'd0,
    OpClimbStep    = 3'd1,
    OpEnable       = 3'd2,
    OpDisable      = 3'd3,
    OpAutoOn       = 3'd4,
    OpAutoOff      = 3'd5,
    OpManualDuty   = 3'd6
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CfgDutyFloor    = 3'd0,
    CfgDutyCeiling  = 3'd1,
    CfgStepSize     = 3'd2,
    CfgBatteryLimit = 3'd3,
    CfgCurrentLimit = 3'd4,
    CfgDeadTime     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic [VOLT_W-1:0]        pv_voltage;
    logic signed [CURR_W-1:0] pv_current;
    logic [VOLT_W-1:0]        battery_voltage;
    logic signed [CURR_W-1:0] battery_current;
    logic [DUTY_W-1:0]        manual_duty;
  } in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_percent;
    logic [CMP_W-1:0]  high_compare;
    logic [CMP_W-1:0]  low_start;
    logic [CMP_W-1:0]  low_width;
    logic              output_enabled;
    logic              auto_enabled;
    logic              tripped;
    logic              ceiling_backoff;
  } out_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty_floor;
    logic [DUTY_W-1:0]  duty_ceiling;
    logic [STEP_W-1:0]  step_size;
    logic [VOLT_W-1:0]  battery_limit;
    logic [LIMIT_W-1:0] current_limit;
    logic [DEAD_W-1:0]  dead_time_counts;
  } cfg_t;

  // status after one operation, handed from the control stage to the pwm stage
  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              drive_on;
    logic              tracking_on;
    logic              tripped;
    logic              backoff;
  } res_t;

endpackage

FILE: rtl/mppt_ctrl.sv
// control stage: tracker state and the per-operation update
module mppt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  mppt_pkg::in_t  item_i,
  input  mppt_pkg::cfg_t cfg_i,
  output mppt_pkg::res_t res_o
);

  localparam int unsigned WantW = mppt_pkg::DUTY_W + 2;
  localparam int unsigned MagW  = mppt_pkg::CURR_W + 1;
  localparam int unsigned PW    = mppt_pkg::POWER_W;

  logic [mppt_pkg::DUTY_W-1:0] duty_q, duty_d;
  logic                        drive_q, drive_d;
  logic                        track_q, track_d;
  logic                        down_q, down_d;
  logic signed [PW-1:0]        prev_q, prev_d;

  logic signed [MagW-1:0]  pv_ext, bat_ext;
  logic [MagW-1:0]         pv_mag, bat_mag, lim_ext;
  logic signed [PW-1:0]    pv_v_ext, pv_i_ext, power;
  logic signed [WantW-1:0] duty_s, step_s, man_s;
  logic                    trip, backoff;

  // raise to floor, then lower to min(ceiling, 100); ceiling wins
  function automatic logic [mppt_pkg::DUTY_W-1:0] clamp_duty(
    input logic signed [WantW-1:0]     want,
    input logic [mppt_pkg::DUTY_W-1:0] floor_v,
    input logic [mppt_pkg::DUTY_W-1:0] ceil_v
  );
    logic [mppt_pkg::DUTY_W-1:0] top;
    logic signed [WantW-1:0]     w;
    top = (ceil_v > mppt_pkg::DUTY_FULL_SCALE) ? mppt_pkg::DUTY_FULL_SCALE : ceil_v;
    w = want;
    if (w < $signed({2'b00, floor_v})) w = $signed({2'b00, floor_v});
    if (w > $signed({2'b00, top})) w = $signed({2'b00, top});
    return w[mppt_pkg::DUTY_W-1:0];
  endfunction

  always_comb begin
    pv_ext  = MagW'(item_i.pv_current);
    bat_ext = MagW'(item_i.battery_current);
    pv_mag  = pv_ext[MagW-1] ? MagW'(-pv_ext) : MagW'(pv_ext);
    bat_mag = bat_ext[MagW-1] ? MagW'(-bat_ext) : MagW'(bat_ext);
    lim_ext = MagW'(cfg_i.current_limit);

    pv_v_ext = $signed(PW'(item_i.pv_voltage));
    pv_i_ext = PW'(item_i.pv_current);
    power    = pv_v_ext * pv_i_ext;

    duty_s = $signed({2'b00, duty_q});
    step_s = $signed(WantW'(cfg_i.step_size));
    man_s  = $signed({2'b00, item_i.manual_duty});

    duty_d  = duty_q;
    drive_d = drive_q;
    track_d = track_q;
    down_d  = down_q;
    prev_d  = prev_q;
    trip    = 1'b0;
    backoff = 1'b0;

    case (item_i.operation)
      mppt_pkg::OpCurrentCheck: begin
        if (drive_q && (pv_mag > lim_ext || bat_mag > lim_ext)) begin
          drive_d = 1'b0;
          track_d = 1'b0;
          trip    = 1'b1;
        end
      end
      mppt_pkg::OpClimbStep: begin
        if (track_q && drive_q) begin
          if (item_i.battery_voltage >= cfg_i.battery_limit) begin
            // at the ceiling: back off while above the duty floor, keep direction and stored power
            if (duty_q > cfg_i.duty_floor) begin
              duty_d  = clamp_duty(duty_s - step_s, cfg_i.duty_floor, cfg_i.duty_ceiling);
              drive_d = 1'b1;
              backoff = 1'b1;
            end
          end else begin
            if (!(power > prev_q)) down_d = !down_q;
            duty_d  = clamp_duty(down_d ? duty_s - step_s : duty_s + step_s,
                                 cfg_i.duty_floor, cfg_i.duty_ceiling);
            drive_d = 1'b1;
            prev_d  = power;
          end
        end
      end
      mppt_pkg::OpEnable: begin
        duty_d  = clamp_duty(duty_s, cfg_i.duty_floor, cfg_i.duty_ceiling);
        drive_d = 1'b1;
      end
      mppt_pkg::OpDisable: begin
        drive_d = 1'b0;
      end
      mppt_pkg::OpAutoOn: begin
        track_d = 1'b1;
        prev_d  = '0;
      end
      mppt_pkg::OpAutoOff: begin
        track_d = 1'b0;
      end
      mppt_pkg::OpManualDuty: begin
        track_d = 1'b0;
        duty_d  = clamp_duty(man_s, cfg_i.duty_floor, cfg_i.duty_ceiling);
        drive_d = 1'b1;
      end
      default: begin
      end
    endcase

    res_o.duty        = duty_d;
    res_o.drive_on    = drive_d;
    res_o.tracking_on = track_d;
    res_o.tripped     = trip;
    res_o.backoff     = backoff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q  <= mppt_pkg::RST_DUTY_NOW;
      drive_q <= 1'b0;
      track_q <= 1'b0;
      down_q  <= 1'b0;
      prev_q  <= '0;
    end else if (en_i && valid_i) begin
      duty_q  <= duty_d;
      drive_q <= drive_d;
      track_q <= track_d;
      down_q  <= down_d;
      prev_q  <= prev_d;
    end
  end

endmodule

FILE: rtl/mppt_pwm.sv
// pwm stage: complementary compare values with dead time from the held duty
module mppt_pwm #(
  parameter int unsigned PeriodCounts = mppt_pkg::PERIOD_COUNTS
) (
  input  mppt_pkg::res_t               res_i,
  input  logic [mppt_pkg::DEAD_W-1:0]  dead_i,
  output logic [mppt_pkg::CMP_W-1:0]   high_compare_o,
  output logic [mppt_pkg::CMP_W-1:0]   low_start_o,
  output logic [mppt_pkg::CMP_W-1:0]   low_width_o
);

  localparam int unsigned CntW = $clog2(PeriodCounts + 1);
  localparam int unsigned MinW = mppt_pkg::DEAD_W + 1;
  localparam int unsigned SW   = ((CntW > MinW) ? CntW : MinW) + 2;

  logic signed [SW-1:0] duty_cnt_tbl [mppt_pkg::DUTY_LEVELS];

  // floor(duty * period / 100) for every duty code
  for (genvar g = 0; g < mppt_pkg::DUTY_LEVELS; g++) begin : g_tbl
    localparam int unsigned Cnt = (g * PeriodCounts) / 100;
    assign duty_cnt_tbl[g] = SW'(Cnt);
  end

  logic signed [SW-1:0] period, dt, hi_cnt, ls_cnt, lw_cnt;

  always_comb begin
    period = SW'(PeriodCounts);
    dt     = $signed(SW'(dead_i));
    hi_cnt = duty_cnt_tbl[res_i.duty];
    if (hi_cnt + (dt <<< 1) >= period) begin
      hi_cnt = period - (dt <<< 1) - SW'(1);
      if (hi_cnt[SW-1]) hi_cnt = '0;
    end
    ls_cnt = hi_cnt + dt;
    lw_cnt = period - dt - ls_cnt;
    if (lw_cnt[SW-1]) lw_cnt = '0;

    high_compare_o = res_i.drive_on ? hi_cnt[mppt_pkg::CMP_W-1:0] : '0;
    low_start_o    = res_i.drive_on ? ls_cnt[mppt_pkg::CMP_W-1:0] : '0;
    low_width_o    = res_i.drive_on ? lw_cnt[mppt_pkg::CMP_W-1:0] : '0;
  end

endmodule

FILE: rtl/mppt_perturb_observe_pwm.sv
// top level: perturb-and-observe tracker with complementary pwm compare outputs
//
// Channels: in_* carries one operation per beat (current check, climb step,
// enable, disable, auto on, auto off, manual duty); out_* returns exactly one
// status beat per input beat, in order; cfg_* writes one register per beat and
// is always ready. Configuration is expected to change only while idle.
// An accepted beat passes the input register, the control stage and the output
// register on its way to out_*. Throughput: one beat per cycle unless out_* stalls;
// the tracker state is updated in the single control stage, so a climb step sees
// the state left by the previous beat.
// The control stage holds one 31-bit signed multiply and its compare; the pwm
// stage is a duty-to-count table lookup plus dead-time adds.
// Reset: duty 40, output and auto mode off, direction up, stored power zero,
// registers at their defaults, pipeline empty.
// Stall: while out_valid_o is high and out_ready_i low the whole pipeline
// holds and in_ready_o is low; otherwise in_ready_o is high.
module mppt_perturb_observe_pwm #(
  parameter int unsigned PeriodCounts = mppt_pkg::PERIOD_COUNTS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  mppt_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output mppt_pkg::out_t                 out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mppt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mppt_pkg::CFG_W-1:0]     cfg_value_i
);

  mppt_pkg::cfg_t cfg_q;
  mppt_pkg::in_t  item_q;
  mppt_pkg::res_t res_d, res_q;
  mppt_pkg::out_t out_d, out_q;
  logic           item_vld_q, res_vld_q, out_vld_q;
  logic           en;

  assign en          = !out_vld_q || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duty_floor       <= mppt_pkg::RST_DUTY_FLOOR;
      cfg_q.duty_ceiling     <= mppt_pkg::RST_DUTY_CEILING;
      cfg_q.step_size        <= mppt_pkg::RST_STEP_SIZE;
      cfg_q.battery_limit    <= mppt_pkg::RST_BATTERY_LIMIT;
      cfg_q.current_limit    <= mppt_pkg::RST_CURRENT_LIMIT;
      cfg_q.dead_time_counts <= mppt_pkg::RST_DEAD_TIME;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mppt_pkg::CfgDutyFloor:    cfg_q.duty_floor    <= cfg_value_i[mppt_pkg::DUTY_W-1:0];
        mppt_pkg::CfgDutyCeiling:  cfg_q.duty_ceiling  <= cfg_value_i[mppt_pkg::DUTY_W-1:0];
        mppt_pkg::CfgStepSize:     cfg_q.step_size     <= cfg_value_i[mppt_pkg::STEP_W-1:0];
        mppt_pkg::CfgBatteryLimit: cfg_q.battery_limit <= cfg_value_i[mppt_pkg::VOLT_W-1:0];
        mppt_pkg::CfgCurrentLimit: cfg_q.current_limit <= cfg_value_i[mppt_pkg::LIMIT_W-1:0];
        mppt_pkg::CfgDeadTime:
          cfg_q.dead_time_counts <= cfg_value_i[mppt_pkg::DEAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // pipeline valid bits, all stages advance together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else if (en) begin
      item_vld_q <= in_valid_i;
      res_vld_q  <= item_vld_q;
      out_vld_q  <= res_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      item_q <= in_data_i;
      res_q  <= res_d;
      out_q  <= out_d;
    end
  end

  mppt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (item_vld_q),
    .item_i  (item_q),
    .cfg_i   (cfg_q),
    .res_o   (res_d)
  );

  mppt_pwm #(
    .PeriodCounts (PeriodCounts)
  ) u_pwm (
    .res_i          (res_q),
    .dead_i         (cfg_q.dead_time_counts),
    .high_compare_o (out_d.high_compare),
    .low_start_o    (out_d.low_start),
    .low_width_o    (out_d.low_width)
  );

  assign out_d.duty_percent    = res_q.duty;
  assign out_d.output_enabled  = res_q.drive_on;
  assign out_d.auto_enabled    = res_q.tracking_on;
  assign out_d.tripped         = res_q.tripped;
  assign out_d.ceiling_backoff = res_q.backoff;

endmodule

FILE: rtl/mppt_chk.sv
// checker: port-level properties of the tracker, bound to the top level
module mppt_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input mppt_pkg::out_t out_data_i
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result beat changed while stalled");

  // compare values are zero whenever the output stage is off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.output_enabled |->
      out_data_i.high_compare == '0 && out_data_i.low_start == '0 &&
      out_data_i.low_width == '0)
    else $error("nonzero compare while output disabled");

  // a trip shuts down both drive and auto mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.tripped |->
      !out_data_i.output_enabled && !out_data_i.auto_enabled)
    else $error("trip left drive or auto mode on");

  // backoff only happens while tracking with the output driving
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.ceiling_backoff |->
      out_data_i.output_enabled && out_data_i.auto_enabled && !out_data_i.tripped)
    else $error("backoff outside tracking");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.duty_percent <= mppt_pkg::DUTY_FULL_SCALE)
    else $error("duty above 100 percent");

endmodule

bind mppt_perturb_observe_pwm mppt_chk u_mppt_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
